// File: hdl/vrt_pkg.sv
// ============================================================================
// vrt_pkg
// Shared types and constants for the voxel ray traversal block.
// ============================================================================
package vrt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam logic [7:0] MAX_DIST_RESET = 8'd16;
  localparam logic [31:0] INF_DIST = 32'hFFFF_FFFF;

  localparam logic [1:0] ST_QUERY = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  localparam logic [1:0] SGN_ZERO  = 2'd0;
  localparam logic [1:0] SGN_PLUS  = 2'd1;
  localparam logic [1:0] SGN_MINUS = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic               chunk_present;
    logic               solid;
  } vrt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic [2:0]         face;
    logic [23:0]        hit_distance;
  } vrt_out_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } vrt_div_req_t;

endpackage

// File: hdl/vrt_div.sv
// ============================================================================
// vrt_div
// Restoring radix-2 divider, one quotient bit per cycle, 64 by 32 bits.
// ============================================================================
module vrt_div
  import vrt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  vrt_div_req_t req,
  output logic         busy,
  output logic [63:0]  quot
);

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sh       = {rem_r[31:0], q_r[63]};
    if (req.start) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign busy = busy_r | req.start;
  assign quot = q_r;

endmodule

// File: hdl/voxel_ray_traversal_unit.sv
// ============================================================================
// voxel_ray_traversal_unit
// Fixed-point 3D voxel grid walk with a shared sequential arithmetic unit.
// ============================================================================
// Sequence: a start item squares and sums the direction components, takes the root, and
// per axis issues the division, waits for the divider, multiplies and stores; a zero
// direction component skips its division. An answer item passes through the step and
// output states. One item is in work at a time; in_ready is low while the sequencer runs
// or a result waits. The divider sets the pace.
// Reset (rst_n, synchronous) clears the ray state and loads max_distance 16.
module voxel_ray_traversal_unit
  import vrt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vrt_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vrt_out_t   out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQRT = 4'd2, S_DIV = 4'd3,
                         S_DIVW = 4'd4, S_MUL = 4'd5, S_FIN = 4'd6, S_STEP = 4'd7,
                         S_OUT = 4'd8;
  localparam logic [63:0] FONE = 64'd1 << FRAC_BITS;
  localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

  logic [3:0]  st_r, st_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic [7:0]  maxd_r;

  vrt_in_t     item_r;
  logic [COORD_BITS-1:0] vox_r [3];
  logic [31:0] nc_r [3];
  logic [31:0] cs_r [3];
  logic [1:0]  sg_r [3];
  logic [31:0] trav_r;
  logic [2:0]  face_r;
  logic        active_r;

  // Shared working registers for sum of squares and root.
  logic [65:0] acc_r;
  logic [63:0] root_r;
  logic [63:0] bit_r;

  vrt_out_t    res_r;
  logic        ov_r;

  vrt_div_req_t dreq;
  logic         dbusy;
  logic [63:0]  dquot;

  vrt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dquot));

  // Per-axis views of the captured item.
  logic [31:0] dsel, osel, mag;
  always_comb begin
    case (ax_r)
      2'd0:    begin dsel = item_r.dir_x; osel = item_r.origin_x; end
      2'd1:    begin dsel = item_r.dir_y; osel = item_r.origin_y; end
      default: begin dsel = item_r.dir_z; osel = item_r.origin_z; end
    endcase
    mag = dsel[31] ? (32'd0 - dsel) : dsel;
  end

  // Root is computed on 64 bits; the 66-bit sum never exceeds 3*2^62 < 2^64.
  logic [63:0] sq_prod;
  logic [63:0] rb;
  assign sq_prod = {32'd0, mag} * {32'd0, mag};
  assign rb = root_r + bit_r;

  // Scaling multiply for the first crossing point.
  logic [32:0] rdist;
  logic [64:0] mprod;
  logic [64:0] mshift;
  always_comb begin
    if (sg_r[ax_r] == SGN_MINUS) rdist = {1'b0, osel & FMASK};
    else rdist = 33'(FONE) - {1'b0, osel & FMASK};
    mprod  = {32'd0, rdist} * {33'd0, cs_r[ax_r]};
    mshift = mprod >> FRAC_BITS;
  end

  // Step: pick the axis with the smallest crossing point.
  logic [1:0]  sax;
  logic [32:0] nsum;
  logic [63:0] lim;
  always_comb begin
    if (nc_r[0] < nc_r[1] && nc_r[0] < nc_r[2]) sax = 2'd0;
    else if (nc_r[1] < nc_r[2]) sax = 2'd1;
    else sax = 2'd2;
    nsum = {1'b0, nc_r[sax]} + {1'b0, cs_r[sax]};
    lim  = {56'd0, maxd_r} << FRAC_BITS;
  end

  function automatic logic [23:0] dist_out(input logic [31:0] d);
    logic [63:0] v;
    begin
      if (FRAC_BITS >= 16) v = {32'd0, d} >> (FRAC_BITS - 16);
      else v = {32'd0, d} << (16 - FRAC_BITS);
      return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    end
  endfunction

  function automatic logic [15:0] lo16(input logic [COORD_BITS-1:0] v);
    logic [31:0] w;
    begin
      w = 32'(v);
      return w[15:0];
    end
  endfunction

  logic accept;
  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_nxt  = st_r;
    ax_nxt  = ax_r;
    dreq.start = 1'b0;
    dreq.num   = {root_r[31:0], 32'd0} >> (32 - FRAC_BITS);
    dreq.den   = mag;
    case (st_r)
      S_IDLE: if (accept) st_nxt = in_data.kind ? S_STEP : S_SQ;
      S_SQ:   if (ax_r == 2'd2) st_nxt = S_SQRT;
      S_SQRT: if (bit_r == 64'd0) st_nxt = S_DIV;
      S_DIV: begin
        if (mag != 32'd0) begin
          dreq.start = 1'b1;
          st_nxt = S_DIVW;
        end else st_nxt = S_FIN;
      end
      S_DIVW: if (!dbusy) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_FIN;
      S_FIN: begin
        if (ax_r == 2'd2) begin
          st_nxt = S_OUT;
        end else begin
          ax_nxt = ax_r + 2'd1;
          st_nxt = S_DIV;
        end
      end
      S_STEP: st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE && accept) ax_nxt = 2'd0;
    if (st_r == S_SQ) ax_nxt = (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ax_r     <= 2'd0;
      maxd_r   <= MAX_DIST_RESET;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      trav_r   <= '0;
      face_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        vox_r[i] <= '0;
        nc_r[i]  <= '0;
        cs_r[i]  <= '0;
        sg_r[i]  <= SGN_ZERO;
      end
    end else begin
      st_r <= st_nxt;
      ax_r <= ax_nxt;
      if (cfg_we) maxd_r <= cfg_data;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (accept) begin
          item_r <= in_data;
          acc_r  <= '0;
        end
        S_SQ: begin
          acc_r <= acc_r + {2'd0, sq_prod};
          if (ax_r == 2'd2) begin
            root_r <= '0;
            bit_r  <= 64'd1 << 62;
          end
        end
        S_SQRT: if (bit_r != 64'd0) begin
          if (bit_r > acc_r[63:0] && root_r == 64'd0) begin
            bit_r <= bit_r >> 2;
          end else if (acc_r[63:0] >= rb) begin
            acc_r  <= {2'd0, acc_r[63:0] - rb};
            root_r <= (root_r >> 1) + bit_r;
            bit_r  <= bit_r >> 2;
          end else begin
            root_r <= root_r >> 1;
            bit_r  <= bit_r >> 2;
          end
        end
        S_DIV: begin
          vox_r[ax_r] <= COORD_BITS'($signed(osel) >>> FRAC_BITS);
          if (mag == 32'd0) begin
            sg_r[ax_r] <= SGN_ZERO;
            cs_r[ax_r] <= INF_DIST;
            nc_r[ax_r] <= INF_DIST;
          end else begin
            sg_r[ax_r] <= dsel[31] ? SGN_MINUS : SGN_PLUS;
          end
        end
        S_DIVW: if (!dbusy)
          cs_r[ax_r] <= (dquot[63:32] != 32'd0) ? INF_DIST : dquot[31:0];
        S_MUL:
          nc_r[ax_r] <= (mshift[64:32] != 33'd0) ? INF_DIST : mshift[31:0];
        S_FIN: if (ax_r == 2'd2) begin
          trav_r   <= '0;
          face_r   <= '0;
          active_r <= (maxd_r != 8'd0);
        end
        S_STEP: begin
          if (!active_r) begin
            res_r <= '{status: ST_MISS, voxel_x: '0, voxel_y: '0, voxel_z: '0,
                       face: '0, hit_distance: '0};
          end else if (!item_r.chunk_present) begin
            active_r <= 1'b0;
            res_r <= '{status: ST_MISS, voxel_x: '0, voxel_y: '0, voxel_z: '0,
                       face: '0, hit_distance: dist_out(trav_r)};
          end else if (item_r.solid) begin
            active_r <= 1'b0;
            res_r <= '{status: ST_HIT, voxel_x: lo16(vox_r[0]), voxel_y: lo16(vox_r[1]),
                       voxel_z: lo16(vox_r[2]), face: face_r,
                       hit_distance: dist_out(trav_r)};
          end else if (nc_r[sax] == INF_DIST || sg_r[sax] == SGN_ZERO) begin
            active_r <= 1'b0;
            res_r <= '{status: ST_MISS, voxel_x: '0, voxel_y: '0, voxel_z: '0,
                       face: '0, hit_distance: dist_out(trav_r)};
          end else begin
            if (sg_r[sax] == SGN_PLUS) begin
              vox_r[sax] <= vox_r[sax] + COORD_BITS'(1);
              face_r     <= {sax, 1'b0} + 3'd2;
            end else begin
              vox_r[sax] <= vox_r[sax] - COORD_BITS'(1);
              face_r     <= {sax, 1'b0} + 3'd1;
            end
            trav_r    <= nc_r[sax];
            nc_r[sax] <= nsum[32] ? INF_DIST : nsum[31:0];
            if ({32'd0, nc_r[sax]} >= lim) begin
              active_r <= 1'b0;
              res_r <= '{status: ST_MISS, voxel_x: '0, voxel_y: '0, voxel_z: '0,
                         face: '0, hit_distance: dist_out(nc_r[sax])};
            end else begin
              res_r.status <= ST_QUERY;
              res_r.face   <= (sg_r[sax] == SGN_PLUS) ? ({sax, 1'b0} + 3'd2)
                                                      : ({sax, 1'b0} + 3'd1);
              res_r.hit_distance <= dist_out(nc_r[sax]);
              res_r.voxel_x <= lo16((sax == 2'd0) ? ((sg_r[0] == SGN_PLUS) ?
                               vox_r[0] + COORD_BITS'(1) : vox_r[0] - COORD_BITS'(1))
                               : vox_r[0]);
              res_r.voxel_y <= lo16((sax == 2'd1) ? ((sg_r[1] == SGN_PLUS) ?
                               vox_r[1] + COORD_BITS'(1) : vox_r[1] - COORD_BITS'(1))
                               : vox_r[1]);
              res_r.voxel_z <= lo16((sax == 2'd2) ? ((sg_r[2] == SGN_PLUS) ?
                               vox_r[2] + COORD_BITS'(1) : vox_r[2] - COORD_BITS'(1))
                               : vox_r[2]);
            end
          end
        end
        S_OUT: begin
          ov_r <= 1'b1;
          // A start with a zero limit ends the ray at once; the setup has
          // already cleared the active flag in that case.
          if (!item_r.kind) begin
            if (!active_r)
              res_r <= '{status: ST_MISS, voxel_x: '0, voxel_y: '0, voxel_z: '0,
                         face: '0, hit_distance: '0};
            else
              res_r <= '{status: ST_QUERY, voxel_x: lo16(vox_r[0]),
                         voxel_y: lo16(vox_r[1]), voxel_z: lo16(vox_r[2]),
                         face: '0, hit_distance: '0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

  // A result is never presented while the sequencer is still working.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (st_r == S_IDLE)) else $error("result valid while busy");
  // The divider is started only from its issue state.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> (st_r == S_DIV)) else $error("stray divider start");
  // After any item finishes, the next state offers the result.
  a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> ov_r) else $error("result lost");

endmodule

// File: tb/tb_voxel_ray_traversal_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_voxel_ray_traversal_unit
// Self-checking testbench for the voxel ray traversal block. Rays are started
// and walked with directed and random answers, and every result is compared field by field
// with a fixed-point predictor of the grid walk held in a scoreboard class.
// ============================================================================

// Scoreboard: keeps a copy of the ray state, predicts the result of every
// accepted item and checks the results that the block returns.
class ray_walk_scoreboard;
  logic [7:0]  max_dist;
  logic [15:0] voxel[3];
  logic [31:0] cross_at[3];
  logic [31:0] cross_inc[3];
  logic [1:0]  dir_sgn[3];
  logic [31:0] dist_done;
  logic [2:0]  face_in;
  bit          walking;
  vrt_pkg::vrt_out_t pending[$];
  int          errors;

  function new();
    max_dist = vrt_pkg::MAX_DIST_RESET;
    for (int i = 0; i < 3; i++) begin
      voxel[i] = '0; cross_at[i] = '0; cross_inc[i] = '0; dir_sgn[i] = vrt_pkg::SGN_ZERO;
    end
    dist_done = '0; face_in = '0; walking = 0; errors = 0;
  endfunction

  static function logic [31:0] clamp32(logic [64:0] v);
    return (v > 65'hFFFF_FFFF) ? vrt_pkg::INF_DIST : v[31:0];
  endfunction

  static function logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0; b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b); res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function void push(logic [1:0] st, bit with_pos, logic [31:0] d);
    vrt_pkg::vrt_out_t r;
    r.status = st;
    r.voxel_x = with_pos ? voxel[0] : '0;
    r.voxel_y = with_pos ? voxel[1] : '0;
    r.voxel_z = with_pos ? voxel[2] : '0;
    r.face = with_pos ? face_in : '0;
    r.hit_distance = (d > 32'hFF_FFFF) ? 24'hFF_FFFF : d[23:0];
    pending.push_back(r);
  endfunction

  function void set_limit(logic [7:0] v);
    max_dist = v;
  endfunction

  // Notes an accepted input item and queues its expected result.
  function void note_item(vrt_pkg::vrt_in_t it);
    logic [31:0] org[3], dv[3];
    logic [63:0] mag[3], sumsq, len, r;
    int ax;
    if (!it.kind) begin
      org[0] = it.origin_x; org[1] = it.origin_y; org[2] = it.origin_z;
      dv[0] = it.dir_x; dv[1] = it.dir_y; dv[2] = it.dir_z;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = dv[i][31] ? (64'h1_0000_0000 - dv[i]) : {32'h0, dv[i]};
        sumsq = sumsq + mag[i] * mag[i];
      end
      len = root64(sumsq);
      for (int i = 0; i < 3; i++) begin
        voxel[i] = org[i][31:16];
        if (mag[i] == 0) begin
          dir_sgn[i] = vrt_pkg::SGN_ZERO;
          cross_inc[i] = vrt_pkg::INF_DIST; cross_at[i] = vrt_pkg::INF_DIST;
        end else begin
          cross_inc[i] = clamp32({1'b0, (len << 16) / mag[i]});
          if (dv[i][31]) begin
            dir_sgn[i] = vrt_pkg::SGN_MINUS; r = org[i][15:0];
          end else begin
            dir_sgn[i] = vrt_pkg::SGN_PLUS; r = 64'h1_0000 - org[i][15:0];
          end
          cross_at[i] = clamp32({1'b0, (r * cross_inc[i]) >> 16});
        end
      end
      dist_done = 0; face_in = 0; walking = 1;
      if (max_dist == 0) begin
        walking = 0; push(vrt_pkg::ST_MISS, 0, dist_done);
      end else begin
        push(vrt_pkg::ST_QUERY, 1, dist_done);
      end
      return;
    end
    if (!walking) begin
      push(vrt_pkg::ST_MISS, 0, 0); return;
    end
    if (!it.chunk_present) begin
      walking = 0; push(vrt_pkg::ST_MISS, 0, dist_done); return;
    end
    if (it.solid) begin
      walking = 0; push(vrt_pkg::ST_HIT, 1, dist_done); return;
    end
    // Smallest crossing wins; a tie goes to the later axis, z over y and y over x.
    if (cross_at[0] < cross_at[1] && cross_at[0] < cross_at[2]) ax = 0;
    else if (cross_at[1] < cross_at[2]) ax = 1;
    else ax = 2;
    if (cross_at[ax] == vrt_pkg::INF_DIST || dir_sgn[ax] == vrt_pkg::SGN_ZERO) begin
      walking = 0; push(vrt_pkg::ST_MISS, 0, dist_done); return;
    end
    if (dir_sgn[ax] == vrt_pkg::SGN_PLUS) begin
      voxel[ax] = voxel[ax] + 1; face_in = 3'(2 * ax + 2);
    end else begin
      voxel[ax] = voxel[ax] - 1; face_in = 3'(2 * ax + 1);
    end
    dist_done = cross_at[ax];
    cross_at[ax] = clamp32({33'h0, cross_at[ax]} + cross_inc[ax]);
    if ({24'h0, dist_done} >= ({32'h0, max_dist} << 16)) begin
      walking = 0; push(vrt_pkg::ST_MISS, 0, dist_done);
    end else begin
      push(vrt_pkg::ST_QUERY, 1, dist_done);
    end
  endfunction

  // Checks one result against the oldest expectation.
  function void check_result(vrt_pkg::vrt_out_t got);
    vrt_pkg::vrt_out_t e;
    if (pending.size() == 0) begin
      $error("unexpected result status=%0d", got.status); errors++; return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, got.status); errors++;
    end
    if (got.voxel_x !== e.voxel_x) begin
      $error("voxel_x: expected %0d, got %0d", e.voxel_x, got.voxel_x); errors++;
    end
    if (got.voxel_y !== e.voxel_y) begin
      $error("voxel_y: expected %0d, got %0d", e.voxel_y, got.voxel_y); errors++;
    end
    if (got.voxel_z !== e.voxel_z) begin
      $error("voxel_z: expected %0d, got %0d", e.voxel_z, got.voxel_z); errors++;
    end
    if (got.face !== e.face) begin
      $error("face: expected %0d, got %0d", e.face, got.face); errors++;
    end
    if (got.hit_distance !== e.hit_distance) begin
      $error("hit_distance: expected %0h, got %0h", e.hit_distance, got.hit_distance);
      errors++;
    end
  endfunction
endclass

module tb_voxel_ray_traversal_unit;
  import vrt_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vrt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vrt_out_t out_data;
  logic     cfg_we;
  logic [7:0] cfg_data;

  ray_walk_scoreboard sb;
  // When set, neither side inserts idle cycles (the final stretch of the run).
  bit       calm;

  voxel_ray_traversal_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Results are sampled at the rising edge; the scoreboard checks each one
  // accepted by the handshake.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // The receiver stalls in random bursts unless the run is in its calm part.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Sends one item: from the next falling edge an optional idle burst, then
  // valid held until accepted. The block is busy right after an acceptance,
  // so starting at the next falling edge costs no throughput. The item is
  // recorded at the edge that accepts it.
  task automatic send_item(vrt_in_t it);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_start(logic [31:0] ox, oy, oz, dx, dy, dz);
    vrt_in_t it;
    it = '0;
    it.kind = 1'b0;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
    send_item(it);
  endtask

  // An answer carries random noise in the ray fields, which the block ignores.
  task automatic send_answer(bit present, bit is_solid);
    vrt_in_t it;
    it = '0;
    it.origin_x = $urandom; it.origin_y = $urandom; it.origin_z = $urandom;
    it.dir_x = $urandom; it.dir_y = $urandom; it.dir_z = $urandom;
    it.kind = 1'b1;
    it.chunk_present = present;
    it.solid = is_solid;
    send_item(it);
  endtask

  // Waits until all expected results are in, then lets the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Changes the distance limit; only called while the block is idle.
  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Random coordinate: mostly small and near the grid origin, sometimes full range.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
  endfunction

  // Random direction component; zero and full-range values are included.
  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  // One ray: start, then mostly empty voxels until a hit, an absent chunk, the
  // block ending it by itself or max_steps answers.
  task automatic walk_ray(int max_steps, ref int items);
    int k;
    send_start(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
    items++;
    k = 0;
    while (k < max_steps && sb.walking) begin
      case ($urandom_range(0, 19))
        0: send_answer(1'b0, 1'($urandom_range(0, 1)));
        1: send_answer(1'b1, 1'b1);
        default: send_answer(1'b1, 1'b0);
      endcase
      items++; k++;
    end
  endtask

  initial begin
    int items;
    sb = new();
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_data = '0;
    calm = 0; items = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: answer with no ray, zero direction, extremes, each axis
    // direction, absent chunk, hit, and ties between crossings.
    send_answer(1'b1, 1'b0);
    send_start(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_answer(1'b1, 1'b0);
    send_start(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b1);
    send_start(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b0);
    send_answer(1'b0, 1'b1);
    send_start(32'hFFFF_8000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b1);
    send_start(32'h7FFF_8000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b0);

    // Limit 1: the first step past one voxel ends the ray; a zero limit then ends a start at once.
    write_limit(8'd1);
    send_start(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0);
    send_answer(1'b1, 1'b0);
    send_answer(1'b1, 1'b0);
    write_limit(8'd0);
    send_start(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_answer(1'b1, 1'b0);

    // Random part over several limits: 4, the largest 255, then a random one.
    write_limit(8'd4);
    while (items < 120) walk_ray(12, items);
    write_limit(8'd255);
    while (items < 240) walk_ray(40, items);
    write_limit(8'($urandom_range(1, 254)));
    while (items < 340) walk_ray(20, items);
    calm = 1;
    while (items < 400) walk_ray(20, items);

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: even if every item were a start under the longest idles and
  // stalls, the run stays near 2.5 ms, so 25 ms is ample.
  initial begin
    #25000000;
    $display("FAIL");
    $finish;
  end
endmodule
